>>> sv/lppm_pkg.sv
// ----------------------------------------------------------------------------
// lppm_pkg: shared types and constants of the layer priority palette mixer
// Word formats, configuration register indexes, layer codes and palette
// offsets used by the front end, the job queue and the palette back end.
// ----------------------------------------------------------------------------
package lppm_pkg;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int unsigned COLOR_W       = 12;
  localparam int unsigned LINE_WIDTH    = 160;
  localparam int unsigned QUEUE_DEPTH   = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_IS_COLOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATE_SHADES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_OFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_COLOR = 3'd4;

  // Input codes
  localparam logic       ACT_MIX       = 1'b0;
  localparam logic       ACT_WRITE     = 1'b1;
  localparam logic [1:0] SPR_PRI1      = 2'd1;
  localparam logic [1:0] SPR_PRI2      = 2'd2;
  localparam logic [1:0] SPR_PRI3      = 2'd3;
  localparam logic [1:0] LVL_PRI0      = 2'd1;
  localparam logic [1:0] LVL_PRI1      = 2'd2;
  localparam logic [3:0] WINDOW_ABSENT = 4'd8;

  // Palette offsets per layer
  localparam logic [PAL_AW-1:0] OFS_SPRITE_NATIVE = 8'h00;
  localparam logic [PAL_AW-1:0] OFS_SPRITE_COMPAT = 8'hc0;
  localparam logic [PAL_AW-1:0] OFS_PLANE1_NATIVE = 8'h40;
  localparam logic [PAL_AW-1:0] OFS_PLANE1_COMPAT = 8'hd0;
  localparam logic [PAL_AW-1:0] OFS_PLANE2_NATIVE = 8'h80;
  localparam logic [PAL_AW-1:0] OFS_PLANE2_COMPAT = 8'he0;
  localparam logic [PAL_AW-1:0] OFS_BACKGROUND    = 8'hf0;
  localparam logic [PAL_AW-1:0] OFS_WINDOW        = 8'hf8;

  localparam logic [COLOR_W-1:0] SHADE_INVERT = 12'h007;

  typedef struct packed {
    logic        action;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [1:0]  sprite_priority;
    logic [5:0]  sprite_color;
    logic [1:0]  plane1_level;
    logic [5:0]  plane1_color;
    logic [1:0]  plane2_level;
    logic [5:0]  plane2_color;
    logic [3:0]  window_code;
    logic [7:0]  palette_index;
    logic [11:0] palette_value;
  } mix_in_t;

  typedef struct packed {
    logic [7:0]  out_x;
    logic [7:0]  out_y;
    logic [11:0] pixel_color;
  } mix_out_t;

  typedef struct packed {
    logic       model_is_color;
    logic       color_mode;
    logic       negate_shades;
    logic       background_off;
    logic [2:0] background_color;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_WRITE,
    JOB_PAL,
    JOB_DIRECT
  } job_kind_e;

  typedef struct packed {
    job_kind_e          kind;
    logic [PAL_AW-1:0]  addr;
    logic [COLOR_W-1:0] data;
    logic [7:0]         x;
    logic [7:0]         y;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

>>> sv/lppm_ram.sv
// ----------------------------------------------------------------------------
// lppm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lppm_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lppm_front.sv
// ----------------------------------------------------------------------------
// lppm_front: input classification and layer priority resolution
// Turns each accepted word into a palette write job, a palette lookup job
// or a direct shade job, and drops pixels that fall outside the line.
// ----------------------------------------------------------------------------
module lppm_front (
  input  logic              in_valid_i,
  input  lppm_pkg::mix_in_t in_word_i,
  input  lppm_pkg::cfg_t    cfg_i,
  input  lppm_pkg::q_stat_t q_stat_i,
  output logic              in_stall_o,
  output logic              push_o,
  output lppm_pkg::job_t    job_o
);

  logic                          sel_any;
  logic [5:0]                    sel_val;
  logic [lppm_pkg::PAL_AW-1:0]   sel_base;
  logic [lppm_pkg::PAL_AW-1:0]   spr_base;
  logic [lppm_pkg::PAL_AW-1:0]   pl1_base;
  logic [lppm_pkg::PAL_AW-1:0]   pl2_base;
  logic [lppm_pkg::COLOR_W-1:0]  shade;
  logic                          in_line;

  assign spr_base = cfg_i.color_mode ? lppm_pkg::OFS_SPRITE_COMPAT
                                     : lppm_pkg::OFS_SPRITE_NATIVE;
  assign pl1_base = cfg_i.color_mode ? lppm_pkg::OFS_PLANE1_COMPAT
                                     : lppm_pkg::OFS_PLANE1_NATIVE;
  assign pl2_base = cfg_i.color_mode ? lppm_pkg::OFS_PLANE2_COMPAT
                                     : lppm_pkg::OFS_PLANE2_NATIVE;

  // Layers in rising priority; the last one that applies wins.
  always_comb begin
    sel_any  = 1'b0;
    sel_val  = '0;
    sel_base = '0;
    if (!cfg_i.background_off) begin
      sel_any  = 1'b1;
      sel_val  = {3'b000, cfg_i.background_color};
      sel_base = lppm_pkg::OFS_BACKGROUND;
    end
    if (in_word_i.sprite_priority == lppm_pkg::SPR_PRI1) begin
      sel_any  = 1'b1;
      sel_val  = in_word_i.sprite_color;
      sel_base = spr_base;
    end
    if (in_word_i.plane1_level == lppm_pkg::LVL_PRI0) begin
      sel_any  = 1'b1;
      sel_val  = in_word_i.plane1_color;
      sel_base = pl1_base;
    end
    if (in_word_i.plane2_level == lppm_pkg::LVL_PRI0) begin
      sel_any  = 1'b1;
      sel_val  = in_word_i.plane2_color;
      sel_base = pl2_base;
    end
    if (in_word_i.sprite_priority == lppm_pkg::SPR_PRI2) begin
      sel_any  = 1'b1;
      sel_val  = in_word_i.sprite_color;
      sel_base = spr_base;
    end
    if (in_word_i.plane1_level == lppm_pkg::LVL_PRI1) begin
      sel_any  = 1'b1;
      sel_val  = in_word_i.plane1_color;
      sel_base = pl1_base;
    end
    if (in_word_i.plane2_level == lppm_pkg::LVL_PRI1) begin
      sel_any  = 1'b1;
      sel_val  = in_word_i.plane2_color;
      sel_base = pl2_base;
    end
    if (in_word_i.sprite_priority == lppm_pkg::SPR_PRI3) begin
      sel_any  = 1'b1;
      sel_val  = in_word_i.sprite_color;
      sel_base = spr_base;
    end
    if (in_word_i.window_code < lppm_pkg::WINDOW_ABSENT) begin
      sel_any  = 1'b1;
      sel_val  = {3'b000, in_word_i.window_code[2:0]};
      sel_base = lppm_pkg::OFS_WINDOW;
    end
  end

  // Monochrome shades pass straight through unless negate_shades inverts them.
  assign shade = {6'b000000, sel_val} ^
                 ((!cfg_i.model_is_color && cfg_i.negate_shades)
                  ? lppm_pkg::SHADE_INVERT : '0);

  assign in_line = {1'b0, in_word_i.pixel_x} < 9'(lppm_pkg::LINE_WIDTH);

  always_comb begin
    job_o.x = in_word_i.pixel_x;
    job_o.y = in_word_i.pixel_y;
    if (in_word_i.action == lppm_pkg::ACT_WRITE) begin
      job_o.kind = lppm_pkg::JOB_WRITE;
      job_o.addr = in_word_i.palette_index;
      job_o.data = in_word_i.palette_value;
    end else if (cfg_i.model_is_color && sel_any) begin
      job_o.kind = lppm_pkg::JOB_PAL;
      job_o.addr = sel_base + {2'b00, sel_val};
      job_o.data = '0;
    end else begin
      // Also covers the color model with no layer present: color zero.
      job_o.kind = lppm_pkg::JOB_DIRECT;
      job_o.addr = '0;
      job_o.data = shade;
    end
  end

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full &&
                      ((in_word_i.action == lppm_pkg::ACT_WRITE) || in_line);

endmodule

>>> sv/lppm_queue.sv
// ----------------------------------------------------------------------------
// lppm_queue: job queue between front end and palette back end
// A small first-in first-out buffer with push and pop in the same cycle.
// ----------------------------------------------------------------------------
module lppm_queue #(
  parameter int unsigned QueueDepth = lppm_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lppm_pkg::job_t    push_data_i,
  input  logic              pop_i,
  output lppm_pkg::job_t    pop_data_o,
  output lppm_pkg::q_stat_t status_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  lppm_pkg::job_t slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = slot_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(QueueDepth));

endmodule

>>> sv/lppm_back.sv
// ----------------------------------------------------------------------------
// lppm_back: palette storage and output stage
// Executes queued jobs in order: palette writes, palette lookups and
// direct shades. Holds the finished word until the consumer takes it.
// ----------------------------------------------------------------------------
module lppm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  lppm_pkg::job_t     job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lppm_pkg::mix_out_t out_word_o
);

  logic [lppm_pkg::PALETTE_DEPTH-1:0] pal_valid_q, pal_valid_d;
  logic                               out_valid_q, out_valid_d;
  logic [7:0]                         out_x_q, out_y_q;
  logic                               use_pal_q, hit_q;
  logic [lppm_pkg::COLOR_W-1:0]       direct_q;
  logic [lppm_pkg::COLOR_W-1:0]       ram_rdata;
  logic                               is_write, out_free, take_pixel;
  logic                               ram_we, ram_re;

  assign is_write   = (job_i.kind == lppm_pkg::JOB_WRITE);
  assign out_free   = !out_valid_q || !out_stall_i;
  // Writes never touch the output stage, so they drain even while it is held.
  assign pop_o      = job_valid_i && (is_write || out_free);
  assign take_pixel = pop_o && !is_write;
  assign ram_we     = pop_o && is_write;
  assign ram_re     = pop_o && (job_i.kind == lppm_pkg::JOB_PAL);

  lppm_ram #(
    .Width (lppm_pkg::COLOR_W),
    .Depth (lppm_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (job_i.addr),
    .wdata_i (job_i.data),
    .re_i    (ram_re),
    .raddr_i (job_i.addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    pal_valid_d = pal_valid_q;
    if (ram_we) begin
      pal_valid_d[job_i.addr] = 1'b1;
    end
    if (take_pixel) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pal_valid_q <= pal_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_pixel) begin
      out_x_q   <= job_i.x;
      out_y_q   <= job_i.y;
      use_pal_q <= (job_i.kind == lppm_pkg::JOB_PAL);
      hit_q     <= pal_valid_q[job_i.addr];
      direct_q  <= job_i.data;
    end
  end

  // An entry never written since reset reads as zero.
  assign out_valid_o            = out_valid_q;
  assign out_word_o.out_x       = out_x_q;
  assign out_word_o.out_y       = out_y_q;
  assign out_word_o.pixel_color = use_pal_q ? (hit_q ? ram_rdata : '0) : direct_q;

endmodule

>>> sv/layer_priority_palette_mixer.sv
// ----------------------------------------------------------------------------
// layer_priority_palette_mixer: per-pixel layer compositor with palette
// Resolves layer priority for one pixel and looks up its palette color or shade.
// ----------------------------------------------------------------------------
// The mixer takes one word per clock while the job queue has room and sustains
// one pixel per clock while the output is not stalled. An accepted pixel word
// passes through the job queue, then into the output register together with the
// registered palette read. Palette write words take the same path, are applied in
// order with the pixels, and produce no output word; pixels with pixel_x beyond
// the line are dropped. The 256-entry palette reads as zero after reset through
// per-entry valid flags, so no clearing pass is needed. The input stalls only
// when the job queue is full, which happens only after the output has been
// stalled. Configuration must be written while the mixer is idle.
// ----------------------------------------------------------------------------
module layer_priority_palette_mixer #(
  parameter int unsigned QueueDepth = lppm_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lppm_pkg::mix_in_t                   in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lppm_pkg::mix_out_t                  out_word_o,
  input  logic                                cfg_we_i,
  input  logic [lppm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lppm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  lppm_pkg::cfg_t    cfg_q, cfg_d;
  lppm_pkg::q_stat_t q_stat;
  lppm_pkg::job_t    push_job, pop_job;
  logic              push, pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lppm_pkg::CFG_MODEL_IS_COLOR:   cfg_d.model_is_color   = cfg_data_i[0];
        lppm_pkg::CFG_COLOR_MODE:       cfg_d.color_mode       = cfg_data_i[0];
        lppm_pkg::CFG_NEGATE_SHADES:    cfg_d.negate_shades    = cfg_data_i[0];
        lppm_pkg::CFG_BACKGROUND_OFF:   cfg_d.background_off   = cfg_data_i[0];
        lppm_pkg::CFG_BACKGROUND_COLOR: cfg_d.background_color = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.model_is_color   <= 1'b1;
      cfg_q.color_mode       <= 1'b0;
      cfg_q.negate_shades    <= 1'b0;
      cfg_q.background_off   <= 1'b0;
      cfg_q.background_color <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lppm_front u_front (
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .cfg_i      (cfg_q),
    .q_stat_i   (q_stat),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .job_o      (push_job)
  );

  lppm_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .status_o    (q_stat)
  );

  lppm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_stat.empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // The queue never takes a word while full and never gives one while empty.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_stat.full))
    else $error("job queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("job queue underflow");

  // Every pixel job handed to the back end shows up as an output word.
  a_pixel_reaches_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (pop_job.kind != lppm_pkg::JOB_WRITE)) |=> out_valid_o)
    else $error("pixel job lost in back end");

  // A palette write never creates an output word on its own.
  a_write_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (pop_job.kind == lppm_pkg::JOB_WRITE) && !out_valid_o) |=> !out_valid_o)
    else $error("palette write produced an output word");

endmodule

>>> tb/tb_layer_priority_palette_mixer.sv
// ----------------------------------------------------------------------------
// tb_layer_priority_palette_mixer: self-checking bench of the layer mixer
// Drives pixel and palette write words with random gaps against a randomly
// stalling output. A shadow palette and a copy of the configuration predict
// each produced pixel. Directed cases cover layer order, offset wrap and the
// monochrome shades, then random phases run across several configurations.
// ----------------------------------------------------------------------------
module tb_layer_priority_palette_mixer;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HANG_LIMIT   = 400;
  localparam int unsigned LOAD_PHASES  = 8;
  localparam int unsigned PHASE_WORDS  = 70;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  lppm_pkg::mix_in_t               in_word_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  lppm_pkg::mix_out_t              out_word_o;
  logic                            cfg_we_i    = 1'b0;
  logic [lppm_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = lppm_pkg::CFG_MODEL_IS_COLOR;
  logic [lppm_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Shadow state of the mixer, updated as words are accepted.
  logic [lppm_pkg::COLOR_W-1:0] shadow_palette [lppm_pkg::PALETTE_DEPTH];
  lppm_pkg::cfg_t               cur_cfg;
  lppm_pkg::mix_out_t           expected_pixels [$];
  int                           errors      = 0;
  int                           idle_cycles = 0;
  bit                           no_idle     = 1'b0;

  layer_priority_palette_mixer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [lppm_pkg::COLOR_W-1:0] lookup_layer(
      input logic [7:0] value,
      input logic [7:0] native_base,
      input logic [7:0] compat_base);
    logic [7:0] addr;
    if (!cur_cfg.model_is_color) begin
      return {4'h0, value};
    end
    // The 8-bit sum wraps around the palette on its own.
    addr = (cur_cfg.color_mode ? compat_base : native_base) + value;
    return shadow_palette[addr];
  endfunction

  function automatic void predict_word(input lppm_pkg::mix_in_t w);
    logic [lppm_pkg::COLOR_W-1:0] color;
    lppm_pkg::mix_out_t           pix;
    if (w.action == lppm_pkg::ACT_WRITE) begin
      shadow_palette[w.palette_index] = w.palette_value;
      return;
    end
    if (w.pixel_x >= lppm_pkg::LINE_WIDTH) begin
      return;
    end
    color = '0;
    if (!cur_cfg.background_off) begin
      color = lookup_layer({5'b0, cur_cfg.background_color}, lppm_pkg::OFS_BACKGROUND,
                           lppm_pkg::OFS_BACKGROUND);
    end
    if (w.sprite_priority == lppm_pkg::SPR_PRI1) begin
      color = lookup_layer({2'b0, w.sprite_color}, lppm_pkg::OFS_SPRITE_NATIVE,
                           lppm_pkg::OFS_SPRITE_COMPAT);
    end
    if (w.plane1_level == lppm_pkg::LVL_PRI0) begin
      color = lookup_layer({2'b0, w.plane1_color}, lppm_pkg::OFS_PLANE1_NATIVE,
                           lppm_pkg::OFS_PLANE1_COMPAT);
    end
    if (w.plane2_level == lppm_pkg::LVL_PRI0) begin
      color = lookup_layer({2'b0, w.plane2_color}, lppm_pkg::OFS_PLANE2_NATIVE,
                           lppm_pkg::OFS_PLANE2_COMPAT);
    end
    if (w.sprite_priority == lppm_pkg::SPR_PRI2) begin
      color = lookup_layer({2'b0, w.sprite_color}, lppm_pkg::OFS_SPRITE_NATIVE,
                           lppm_pkg::OFS_SPRITE_COMPAT);
    end
    if (w.plane1_level == lppm_pkg::LVL_PRI1) begin
      color = lookup_layer({2'b0, w.plane1_color}, lppm_pkg::OFS_PLANE1_NATIVE,
                           lppm_pkg::OFS_PLANE1_COMPAT);
    end
    if (w.plane2_level == lppm_pkg::LVL_PRI1) begin
      color = lookup_layer({2'b0, w.plane2_color}, lppm_pkg::OFS_PLANE2_NATIVE,
                           lppm_pkg::OFS_PLANE2_COMPAT);
    end
    if (w.sprite_priority == lppm_pkg::SPR_PRI3) begin
      color = lookup_layer({2'b0, w.sprite_color}, lppm_pkg::OFS_SPRITE_NATIVE,
                           lppm_pkg::OFS_SPRITE_COMPAT);
    end
    if (w.window_code < lppm_pkg::WINDOW_ABSENT) begin
      color = lookup_layer({4'h0, w.window_code}, lppm_pkg::OFS_WINDOW, lppm_pkg::OFS_WINDOW);
    end
    if (!cur_cfg.model_is_color && cur_cfg.negate_shades) begin
      color = color ^ lppm_pkg::SHADE_INVERT;
    end
    pix.out_x       = w.pixel_x;
    pix.out_y       = w.pixel_y;
    pix.pixel_color = color;
    expected_pixels.push_back(pix);
  endfunction

  // ------------------------------------------------------------ word builders

  function automatic lppm_pkg::mix_in_t build_pixel(
      input logic [7:0] x, input logic [7:0] y,
      input logic [1:0] spr_pri, input logic [5:0] spr_col,
      input logic [1:0] lvl1, input logic [5:0] col1,
      input logic [1:0] lvl2, input logic [5:0] col2,
      input logic [3:0] win);
    lppm_pkg::mix_in_t w;
    w.action          = lppm_pkg::ACT_MIX;
    w.pixel_x         = x;
    w.pixel_y         = y;
    w.sprite_priority = spr_pri;
    w.sprite_color    = spr_col;
    w.plane1_level    = lvl1;
    w.plane1_color    = col1;
    w.plane2_level    = lvl2;
    w.plane2_color    = col2;
    w.window_code     = win;
    // The palette operands are don't-care on a pixel word.
    w.palette_index   = 8'($urandom_range(0, 255));
    w.palette_value   = 12'($urandom_range(0, 4095));
    return w;
  endfunction

  function automatic lppm_pkg::mix_in_t build_write(input logic [7:0] idx,
                                                    input logic [11:0] value);
    lppm_pkg::mix_in_t w;
    w = build_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                    2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                    2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                    4'($urandom_range(0, 15)));
    w.action        = lppm_pkg::ACT_WRITE;
    w.palette_index = idx;
    w.palette_value = value;
    return w;
  endfunction

  function automatic lppm_pkg::mix_in_t random_pixel();
    logic [7:0] x;
    logic [3:0] win;
    // Some pixels fall beyond the line; the window is present only now and then.
    x   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(lppm_pkg::LINE_WIDTH, 255))
                                      : 8'($urandom_range(0, lppm_pkg::LINE_WIDTH - 1));
    win = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(8, 15));
    return build_pixel(x, 8'($urandom_range(0, 255)),
                       2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                       2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                       2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), win);
  endfunction

  // ------------------------------------------------------------- drive tasks

  task automatic send_word(input lppm_pkg::mix_in_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(w);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    // Palette writes give no output word, so let the pipeline empty too.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(input lppm_pkg::cfg_t c);
    wait_for_drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= lppm_pkg::CFG_MODEL_IS_COLOR;
    cfg_data_i <= {2'b00, c.model_is_color};
    @(posedge clk_i);
    cfg_idx_i  <= lppm_pkg::CFG_COLOR_MODE;
    cfg_data_i <= {2'b00, c.color_mode};
    @(posedge clk_i);
    cfg_idx_i  <= lppm_pkg::CFG_NEGATE_SHADES;
    cfg_data_i <= {2'b00, c.negate_shades};
    @(posedge clk_i);
    cfg_idx_i  <= lppm_pkg::CFG_BACKGROUND_OFF;
    cfg_data_i <= {2'b00, c.background_off};
    @(posedge clk_i);
    cfg_idx_i  <= lppm_pkg::CFG_BACKGROUND_COLOR;
    cfg_data_i <= c.background_color;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_cfg = c;
  endtask

  // ----------------------------------------------------------- output side

  always begin : drain_pixels
    int hold;
    hold = no_idle ? 0 : $urandom_range(0, 6);
    if (hold > 0) begin
      out_stall_i <= 1'b1;
      repeat (hold) @(posedge clk_i);
    end
    out_stall_i <= 1'b0;
    do @(posedge clk_i); while (!out_valid_o);
  end

  always @(posedge clk_i) begin : check_pixels
    lppm_pkg::mix_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: pixel with none pending: x=%0d y=%0d color=%h", $time,
                 out_word_o.out_x, out_word_o.out_y, out_word_o.pixel_color);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_word_o.out_x !== want.out_x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, want.out_x, out_word_o.out_x);
          errors++;
        end
        if (out_word_o.out_y !== want.out_y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, want.out_y, out_word_o.out_y);
          errors++;
        end
        if (out_word_o.pixel_color !== want.pixel_color) begin
          $display("%0t: pixel_color expected %h actual %h (x=%0d y=%0d)", $time,
                   want.pixel_color, out_word_o.pixel_color, want.out_x, want.out_y);
          errors++;
        end
      end
    end
  end

  // A run that stops moving words is a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // -------------------------------------------------------------- test cases

  // The palette must read as zero before anything is written.
  task automatic test_reset_palette();
    send_word(build_pixel(8'd0, 8'd0, 2'd0, 6'd0, 2'd0, 6'd0, 2'd0, 6'd0,
                          lppm_pkg::WINDOW_ABSENT));
    send_word(build_pixel(8'd159, 8'd151, lppm_pkg::SPR_PRI3, 6'd63, 2'd0, 6'd0, 2'd0, 6'd0,
                          lppm_pkg::WINDOW_ABSENT));
  endtask

  task automatic test_palette_writes();
    send_word(build_write(8'h00, 12'h123));
    send_word(build_write(8'hff, 12'hfff));
    send_word(build_write(8'h0f, 12'h5a5));
    send_word(build_write(8'h1f, 12'ha5a));
    send_word(build_write(8'hf7, 12'h0f0));
    send_word(build_write(8'hf8, 12'h800));
  endtask

  task automatic test_layer_order();
    load_config(lppm_pkg::cfg_t'{model_is_color: 1'b1, color_mode: 1'b0,
                                 negate_shades: 1'b0, background_off: 1'b0,
                                 background_color: 3'd7});
    send_word(build_pixel(8'd1, 8'd2, 2'd0, 6'd0, 2'd0, 6'd0, 2'd0, 6'd0,
                          lppm_pkg::WINDOW_ABSENT));
    send_word(build_pixel(8'd2, 8'd2, lppm_pkg::SPR_PRI1, 6'd5, lppm_pkg::LVL_PRI0, 6'd9,
                          2'd0, 6'd0, lppm_pkg::WINDOW_ABSENT));
    send_word(build_pixel(8'd3, 8'd2, lppm_pkg::SPR_PRI2, 6'd0, 2'd0, 6'd0,
                          lppm_pkg::LVL_PRI0, 6'd12, lppm_pkg::WINDOW_ABSENT));
    send_word(build_pixel(8'd4, 8'd2, lppm_pkg::SPR_PRI3, 6'd63, lppm_pkg::LVL_PRI1, 6'd1,
                          lppm_pkg::LVL_PRI1, 6'd2, lppm_pkg::WINDOW_ABSENT));
    send_word(build_pixel(8'd5, 8'd2, lppm_pkg::SPR_PRI3, 6'd63, lppm_pkg::LVL_PRI1, 6'd1,
                          lppm_pkg::LVL_PRI1, 6'd2, 4'd0));
    // Plane level 3 and window codes above 8 count as absent.
    send_word(build_pixel(8'd6, 8'd2, 2'd0, 6'd0, 2'd3, 6'd4, 2'd3, 6'd4, 4'd15));
    send_word(build_pixel(8'd160, 8'd2, lppm_pkg::SPR_PRI3, 6'd0, 2'd0, 6'd0, 2'd0, 6'd0,
                          4'd7));
    send_word(build_pixel(8'd255, 8'd255, 2'd0, 6'd0, 2'd0, 6'd0, 2'd0, 6'd0,
                          lppm_pkg::WINDOW_ABSENT));
  endtask

  // Compatible plane offsets plus a large index wrap past the end of the palette.
  task automatic test_compat_wrap();
    load_config(lppm_pkg::cfg_t'{model_is_color: 1'b1, color_mode: 1'b1,
                                 negate_shades: 1'b0, background_off: 1'b1,
                                 background_color: 3'd0});
    send_word(build_pixel(8'd10, 8'd20, 2'd0, 6'd0, lppm_pkg::LVL_PRI1, 6'd63, 2'd0, 6'd0,
                          lppm_pkg::WINDOW_ABSENT));
    send_word(build_pixel(8'd11, 8'd20, 2'd0, 6'd0, 2'd0, 6'd0, lppm_pkg::LVL_PRI0, 6'd63,
                          lppm_pkg::WINDOW_ABSENT));
    send_word(build_pixel(8'd12, 8'd20, lppm_pkg::SPR_PRI1, 6'd63, 2'd0, 6'd0, 2'd0, 6'd0,
                          lppm_pkg::WINDOW_ABSENT));
    send_word(build_pixel(8'd13, 8'd20, 2'd0, 6'd0, 2'd0, 6'd0, 2'd0, 6'd0,
                          lppm_pkg::WINDOW_ABSENT));
  endtask

  task automatic test_mono_shades();
    load_config(lppm_pkg::cfg_t'{model_is_color: 1'b0, color_mode: 1'b0,
                                 negate_shades: 1'b1, background_off: 1'b0,
                                 background_color: 3'd5});
    send_word(build_pixel(8'd30, 8'd40, 2'd0, 6'd0, 2'd0, 6'd0, 2'd0, 6'd0,
                          lppm_pkg::WINDOW_ABSENT));
    send_word(build_pixel(8'd31, 8'd40, 2'd0, 6'd0, 2'd0, 6'd0, 2'd0, 6'd0, 4'd7));
    send_word(build_pixel(8'd32, 8'd40, lppm_pkg::SPR_PRI2, 6'd63, 2'd0, 6'd0, 2'd0, 6'd0,
                          lppm_pkg::WINDOW_ABSENT));
    // With no layer at all the zero color is still inverted.
    load_config(lppm_pkg::cfg_t'{model_is_color: 1'b0, color_mode: 1'b0,
                                 negate_shades: 1'b1, background_off: 1'b1,
                                 background_color: 3'd5});
    send_word(build_pixel(8'd33, 8'd40, 2'd0, 6'd0, 2'd0, 6'd0, 2'd0, 6'd0,
                          lppm_pkg::WINDOW_ABSENT));
  endtask

  task automatic test_palette_load();
    for (int i = 0; i < lppm_pkg::PALETTE_DEPTH; i++) begin
      send_word(build_write(i[7:0], 12'($urandom_range(0, 4095))));
    end
  endtask

  // Mostly pixels with some palette writes mixed in, one configuration per
  // phase; the first two phases take the all-low and all-high settings.
  task automatic test_random_mix();
    lppm_pkg::cfg_t c;
    for (int phase = 0; phase < LOAD_PHASES; phase++) begin
      if (phase == 0) begin
        c = '0;
      end else if (phase == 1) begin
        c = '1;
      end else begin
        c = lppm_pkg::cfg_t'(7'($urandom_range(0, 127)));
      end
      load_config(c);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == PHASE_WORDS / 2) begin
          wait_for_drain();
        end
        if ($urandom_range(0, 6) == 0) begin
          send_word(build_write(8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095))));
        end else begin
          send_word(random_pixel());
        end
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < lppm_pkg::PALETTE_DEPTH; i++) begin
      shadow_palette[i] = '0;
    end
    cur_cfg = '{model_is_color: 1'b1, color_mode: 1'b0, negate_shades: 1'b0,
                background_off: 1'b0, background_color: 3'd0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_palette();
    test_palette_writes();
    test_layer_order();
    test_compat_wrap();
    test_mono_shades();
    test_palette_load();
    test_random_mix();
    wait_for_drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/lppm_pkg.sv
sv/lppm_ram.sv
sv/lppm_front.sv
sv/lppm_queue.sv
sv/lppm_back.sv
sv/layer_priority_palette_mixer.sv
tb/tb_layer_priority_palette_mixer.sv
